@@ rtl/grh_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the gear rolling hash.
// Used by the channel interfaces, the table generator and the top level.
package grh_pkg;

   localparam int HASH_W       = 64;
   localparam int HALF_W       = 32;
   localparam int BYTE_W       = 8;
   localparam int TABLE_DEPTH  = 256;
   localparam int TABLE_ADDR_W = 8;
   localparam int GEN_STAGES   = 5;

   // Constants of the splitmix64 sequence.
   localparam logic [HASH_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [HASH_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [HASH_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
   localparam int MIX_SHIFT_1 = 30;
   localparam int MIX_SHIFT_2 = 27;
   localparam int MIX_SHIFT_3 = 31;

   typedef logic [HASH_W-1:0]       hash_type;
   typedef logic [HALF_W-1:0]       half_type;
   typedef logic [BYTE_W-1:0]       byte_type;
   typedef logic [TABLE_ADDR_W-1:0] addr_type;

   // Write request from the table generator into the gear table.
   typedef struct packed {
      logic     wr_en;
      addr_type addr;
      hash_type data;
   } table_wr_type;

endpackage

@@ rtl/grh_req_if.sv @@
`timescale 1ns / 1ps
// Input channel of the gear rolling hash: one stream byte per request.
// Depends on grh_pkg.
interface grh_req_if;
   import grh_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     window_start;

   modport source (output valid, output data_byte, output window_start, input ready);
   modport sink   (input valid, input data_byte, input window_start, output ready);
endinterface

@@ rtl/grh_rsp_if.sv @@
`timescale 1ns / 1ps
// Result channel of the gear rolling hash: one 64-bit window hash per request.
// Depends on grh_pkg.
interface grh_rsp_if;
   import grh_pkg::*;

   logic     valid;
   logic     ready;
   hash_type window_hash;

   modport source (output valid, output window_hash, input ready);
   modport sink   (input valid, input window_hash, output ready);
endinterface

@@ rtl/grh_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module grh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port; read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/grh_table_gen.sv @@
`timescale 1ns / 1ps
// Gear table generator: runs the splitmix64 sequence through a five-stage
// pipeline and writes one table entry per cycle. Depends on grh_pkg.
module grh_table_gen (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  grh_pkg::hash_type     seed,
   output grh_pkg::table_wr_type table_wr,
   output logic                  busy
);
   import grh_pkg::*;

   // Control state.
   logic                  busy_ff, busy_in;
   logic [TABLE_ADDR_W:0] issue_cnt_ff, issue_cnt_in;
   hash_type              ctr_ff, ctr_in;
   logic [GEN_STAGES-1:0] valid_ff, valid_in;

   // Payload of the stages.
   addr_type addr_ff [GEN_STAGES];
   hash_type s0_x_ff, s0_x_in;
   hash_type s1_plo_ff, s1_plo_in;
   half_type s1_phl_ff, s1_phl_in;
   half_type s1_plh_ff, s1_plh_in;
   hash_type s2_w_ff, s2_w_in;
   hash_type s3_qlo_ff, s3_qlo_in;
   half_type s3_qhl_ff, s3_qhl_in;
   half_type s3_qlh_ff, s3_qlh_in;
   hash_type s4_out_ff, s4_out_in;

   logic     issue;
   logic     last_write;
   hash_type ctr_step;
   hash_type y_sum;
   hash_type z_sum;

   // An entry is issued every cycle until all of the table has been issued.
   assign issue      = busy_ff && !issue_cnt_ff[TABLE_ADDR_W];
   assign last_write = valid_ff[GEN_STAGES-1]
                       && (addr_ff[GEN_STAGES-1] == addr_type'(TABLE_DEPTH - 1));

   // Control next state; a seed write restarts the whole fill.
   always_comb begin
      busy_in      = busy_ff;
      issue_cnt_in = issue_cnt_ff;
      ctr_in       = ctr_ff;
      valid_in     = {valid_ff[GEN_STAGES-2:0], issue};
      if (restart) begin
         busy_in      = 1'b1;
         issue_cnt_in = '0;
         ctr_in       = seed;
         valid_in     = '0;
      end else begin
         if (issue) begin
            issue_cnt_in = issue_cnt_ff + 1'b1;
            ctr_in       = ctr_step;
         end
         if (last_write) begin
            busy_in = 1'b0;
         end
      end
   end

   // Stage 0: advance the counter and apply the first xor-shift.
   assign ctr_step = ctr_ff + GOLDEN_STEP;
   assign s0_x_in  = ctr_step ^ (ctr_step >> MIX_SHIFT_1);

   // Stage 1: partial products for the low 64 bits of x times MIX_MUL_A.
   assign s1_plo_in = HASH_W'(s0_x_ff[HALF_W-1:0]) * HASH_W'(MIX_MUL_A[HALF_W-1:0]);
   assign s1_phl_in = s0_x_ff[HASH_W-1:HALF_W] * MIX_MUL_A[HALF_W-1:0];
   assign s1_plh_in = s0_x_ff[HALF_W-1:0] * MIX_MUL_A[HASH_W-1:HALF_W];

   // Stage 2: sum the partial products and apply the second xor-shift.
   assign y_sum   = s1_plo_ff + {s1_phl_ff + s1_plh_ff, {HALF_W{1'b0}}};
   assign s2_w_in = y_sum ^ (y_sum >> MIX_SHIFT_2);

   // Stage 3: partial products of w times MIX_MUL_B.
   assign s3_qlo_in = HASH_W'(s2_w_ff[HALF_W-1:0]) * HASH_W'(MIX_MUL_B[HALF_W-1:0]);
   assign s3_qhl_in = s2_w_ff[HASH_W-1:HALF_W] * MIX_MUL_B[HALF_W-1:0];
   assign s3_qlh_in = s2_w_ff[HALF_W-1:0] * MIX_MUL_B[HASH_W-1:HALF_W];

   // Stage 4: sum the partial products and apply the final xor-shift.
   assign z_sum     = s3_qlo_ff + {s3_qhl_ff + s3_qlh_ff, {HALF_W{1'b0}}};
   assign s4_out_in = z_sum ^ (z_sum >> MIX_SHIFT_3);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         issue_cnt_ff <= '0;
         ctr_ff       <= '0;
         valid_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         issue_cnt_ff <= issue_cnt_in;
         ctr_ff       <= ctr_in;
         valid_ff     <= valid_in;
      end
   end

   // Stage payload moves every cycle; the valid bits say which of it counts.
   always_ff @(posedge clock) begin
      addr_ff[0] <= issue_cnt_ff[TABLE_ADDR_W-1:0];
      for (int i = 1; i < GEN_STAGES; i++) begin
         addr_ff[i] <= addr_ff[i-1];
      end
      s0_x_ff   <= s0_x_in;
      s1_plo_ff <= s1_plo_in;
      s1_phl_ff <= s1_phl_in;
      s1_plh_ff <= s1_plh_in;
      s2_w_ff   <= s2_w_in;
      s3_qlo_ff <= s3_qlo_in;
      s3_qhl_ff <= s3_qhl_in;
      s3_qlh_ff <= s3_qlh_in;
      s4_out_ff <= s4_out_in;
   end

   assign table_wr.wr_en = valid_ff[GEN_STAGES-1];
   assign table_wr.addr  = addr_ff[GEN_STAGES-1];
   assign table_wr.data  = s4_out_ff;
   assign busy           = busy_ff;

endmodule

@@ rtl/gear_rolling_hash.sv @@
`timescale 1ns / 1ps
// Gear rolling hash, 64-bit, one byte per cycle outside a fill or a stall.
// Depends on grh_pkg, grh_req_if, grh_rsp_if, grh_ram and grh_table_gen.
//
// Usage: each request on req_if carries one stream byte and a window_start
// flag that restarts the hash at that byte. For every request one response
// leaves on rsp_if with the gear hash of the last 64 bytes (fewer after a
// restart): h = (h << 1) + gear[byte], or h = gear[byte] on a restart.
// A table read is registered, then the response register takes the new hash.
// New requests are taken in every cycle outside a fill or stall, bounded by
// the one table read and the 64-bit add that closes the running-hash loop.
// The 256-entry gear table is filled by a five-stage splitmix64 pipeline
// after reset (seed 0) and after each write on csr_wr_en/csr_wr_data; the
// fill keeps req_if.ready low until it ends. Reset clears the running hash
// to zero; a seed write keeps it.
// When the receiver stalls, the response register holds its hash, one more
// request is taken into the table-read stage, and then ready drops until
// the response is taken.
module gear_rolling_hash (
   input  logic              clock,
   input  logic              reset,
   grh_req_if.sink           req_if,
   grh_rsp_if.source         rsp_if,
   input  logic              csr_wr_en,
   input  grh_pkg::hash_type csr_wr_data
);
   import grh_pkg::*;

   table_wr_type table_wr;
   logic         gen_busy;
   hash_type     entry;

   logic     s1_valid_ff, s1_valid_in;
   logic     s1_start_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   hash_type running_hash_ff, running_hash_in;

   logic accept;
   logic advance;
   logic s1_move;

   grh_table_gen u_gen (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_wr_en),
      .seed     (csr_wr_data),
      .table_wr (table_wr),
      .busy     (gen_busy)
   );

   grh_ram #(
      .WIDTH (HASH_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (table_wr.wr_en),
      .wr_addr (table_wr.addr),
      .wr_data (table_wr.data),
      .rd_en   (accept),
      .rd_addr (req_if.data_byte),
      .rd_data (entry)
   );

   // Handshake: the read stage moves on when the response register is free.
   assign advance       = !rsp_valid_ff || rsp_if.ready;
   assign s1_move       = s1_valid_ff && advance;
   assign req_if.ready  = !gen_busy && (!s1_valid_ff || advance);
   assign accept        = req_if.valid && req_if.ready;

   // Valid bits of the read stage and the response register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Running hash update; its register is also the response payload.
   always_comb begin
      running_hash_in = running_hash_ff;
      if (s1_move) begin
         if (s1_start_ff) begin
            running_hash_in = entry;
         end else begin
            running_hash_in = {running_hash_ff[HASH_W-2:0], 1'b0} + entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         running_hash_ff <= '0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         running_hash_ff <= running_hash_in;
      end
   end

   // Restart flag travels alongside the table read.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_start_ff <= req_if.window_start;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.window_hash = running_hash_ff;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gear_rolling_hash: directed and random byte streams with seed changes.
// Depends on grh_pkg, grh_req_if, grh_rsp_if and the gear_rolling_hash RTL.
module tb_top;
   import grh_pkg::*;

   logic     clock;
   logic     reset;
   logic     csr_wr_en;
   hash_type csr_wr_data;

   grh_req_if req_if ();
   grh_rsp_if rsp_if ();

   gear_rolling_hash dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Own copy of the gear table, the running hash and the seed.
   hash_type gear_model [TABLE_DEPTH];
   hash_type model_hash;
   hash_type model_seed;

   // Window hashes predicted for accepted requests, oldest first.
   hash_type window_hash_q [$];

   int unsigned error_count;
   int unsigned send_gap_max;
   int unsigned rsp_stall_max;
   int unsigned restart_pct;
   int unsigned burst_left;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // One output of the splitmix64 mixer for an already advanced counter.
   function automatic hash_type splitmix_mix(hash_type counter);
      hash_type z;
      z = counter;
      z = (z ^ (z >> MIX_SHIFT_1)) * MIX_MUL_A;
      z = (z ^ (z >> MIX_SHIFT_2)) * MIX_MUL_B;
      return z ^ (z >> MIX_SHIFT_3);
   endfunction

   // Rebuilds the whole gear table from a seed.
   task automatic regenerate_gear(input hash_type seed);
      hash_type counter;
      counter = seed;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         counter = counter + GOLDEN_STEP;
         gear_model[k] = splitmix_mix(counter);
      end
      model_seed = seed;
   endtask

   // The next window hash: a restart begins afresh, otherwise the old hash shifts.
   function automatic hash_type next_window_hash(input hash_type prev, input byte_type b,
                                                 input logic restart);
      if (restart) begin
         return gear_model[b];
      end
      return (prev << 1) + gear_model[b];
   endfunction

   task automatic report_mismatch(input hash_type expected_hash, input hash_type actual_hash);
      if (error_count < 10) begin
         $display("window hash mismatch: expected %016h, got %016h (seed %016h)",
                  expected_hash, actual_hash, model_seed);
      end
      error_count++;
   endtask

   // Sends one request, idling between bursts, and records its predicted hash.
   task automatic send_byte(input byte_type b, input logic restart);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (send_gap_max != 0) begin
            gap = $urandom_range(1, send_gap_max);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid        <= 1'b1;
      req_if.data_byte    <= b;
      req_if.window_start <= restart;
      do @(posedge clock); while (!req_if.ready);
      model_hash = next_window_hash(model_hash, b, restart);
      window_hash_q = {window_hash_q, model_hash};
   endtask

   // Stops sending and waits until every predicted hash has been checked.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (window_hash_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the seed register; the block refills its table before taking requests again.
   task automatic write_seed(input hash_type seed);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= seed;
      regenerate_gear(seed);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // The first byte after reset without a restart starts from a zero hash.
   task automatic test_first_byte_after_reset();
      send_byte(8'h5A, 1'b0);
      send_byte(8'h00, 1'b0);
      drain_results();
   endtask

   // Extreme and alternating byte values, with and without restarts.
   task automatic test_field_extremes();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b1);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h00, 1'b0);
      drain_results();
   endtask

   // A seed change in the middle of a stream keeps the running hash.
   task automatic test_seed_change_midstream();
      send_byte(8'h12, 1'b1);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      drain_results();
      write_seed({HASH_W{1'b1}});
      send_byte(8'h78, 1'b0);
      send_byte(8'h9A, 1'b0);
      send_byte(8'hBC, 1'b0);
      drain_results();
   endtask

   // The lowest seed and a single high bit, each followed by a few bytes.
   task automatic test_seed_extremes();
      write_seed('0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h80, 1'b0);
      drain_results();
      write_seed({1'b1, {(HASH_W-1){1'b0}}});
      send_byte(8'hFE, 1'b0);
      send_byte(8'h7F, 1'b1);
      drain_results();
   endtask

   // Random streams in phases of differing idling, stall and restart rates, new seed after each phase.
   task automatic test_random_stream();
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               send_gap_max = 0;  rsp_stall_max = 0;  restart_pct = 0;
            end
            1: begin
               send_gap_max = 6;  rsp_stall_max = 8;  restart_pct = 3;
            end
            2: begin
               send_gap_max = 2;  rsp_stall_max = 30; restart_pct = 25;
            end
            3: begin
               send_gap_max = 12; rsp_stall_max = 0;  restart_pct = 2;
            end
            default: begin
               send_gap_max = 4;  rsp_stall_max = 5;  restart_pct = 8;
            end
         endcase
         for (int n = 0; n < 350; n++) begin
            send_byte(byte_type'($urandom_range(0, 255)),
                      ($urandom_range(0, 99) < restart_pct));
         end
         drain_results();
         write_seed({$urandom, $urandom});
      end
   endtask

   // Receiver: runs of ready broken by stalls of random length.
   initial begin
      int unsigned run;
      rsp_if.ready <= 1'b0;
      forever begin
         run = $urandom_range(1, 16);
         repeat (run) begin
            @(posedge clock);
            rsp_if.ready <= 1'b1;
         end
         if (rsp_stall_max != 0) begin
            run = $urandom_range(1, rsp_stall_max);
            repeat (run) begin
               @(posedge clock);
               rsp_if.ready <= 1'b0;
            end
         end
      end
   end

   // Each accepted response is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (window_hash_q.size() == 0) begin
            if (error_count < 10) begin
               $display("unexpected window hash %016h", rsp_if.window_hash);
            end
            error_count++;
         end else if (rsp_if.window_hash !== window_hash_q[0]) begin
            report_mismatch(window_hash_q.pop_front(), rsp_if.window_hash);
         end else begin
            void'(window_hash_q.pop_front());
         end
      end
   end

   // Main sequence.
   initial begin
      error_count   = 0;
      burst_left    = 0;
      send_gap_max  = 3;
      rsp_stall_max = 4;
      restart_pct   = 0;
      model_hash    = '0;
      regenerate_gear('0);
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_if.valid        <= 1'b0;
      req_if.data_byte    <= '0;
      req_if.window_start <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_first_byte_after_reset();
      test_field_extremes();
      test_seed_change_midstream();
      test_seed_extremes();
      test_random_stream();

      drain_results();
      if (error_count == 0 && window_hash_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #1000000;
      $display("FAILURE");
      $finish;
   end

endmodule
